// File: rtl/core/pcsb_pkg.sv
// Package for the PHAT cross-spectrum bin: beat types, widths and the
// arithmetic helpers of the normalizer. Depends on nothing.
package pcsb_pkg;

	localparam int SampleBits = 16;
	localparam int OutBits    = 16;
	localparam int NormBits   = 15;
	localparam int SqBits     = 2 * NormBits + 1;
	localparam int RootBits   = 31;
	localparam int RemBits    = 63;
	localparam int QuotBits   = 16;
	localparam int DivBits    = NormBits + 32;
	localparam int LeadBits   = $clog2(SampleBits);
	localparam int SqSteps    = RootBits;
	localparam int DivSteps   = QuotBits;
	localparam int ProdBits   = 2 * OutBits + 1;

	localparam logic [QuotBits-1:0] UnitMax = QuotBits'(32767);

	typedef struct packed {
		logic signed [SampleBits-1:0] first_real;
		logic signed [SampleBits-1:0] first_imag;
		logic signed [SampleBits-1:0] second_real;
		logic signed [SampleBits-1:0] second_imag;
		logic                         frame_end;
	} in_beat_t;

	typedef struct packed {
		logic signed [OutBits-1:0] cross_real;
		logic signed [OutBits-1:0] cross_imag;
		logic                      zero_magnitude;
		logic                      frame_end_out;
	} out_beat_t;

	// Signs and marks that ride along the whole pipeline.
	typedef struct packed {
		logic neg_ar;
		logic neg_ai;
		logic neg_br;
		logic neg_bi;
		logic zero;
		logic frame_end;
	} side_t;

	typedef struct packed {
		logic [NormBits-1:0] mr;
		logic [NormBits-1:0] mi;
		logic [RemBits-1:0]  rem;
		logic [RootBits-1:0] root;
	} sq_bin_t;

	typedef struct packed {
		logic [DivBits-1:0]  rem_r;
		logic [DivBits-1:0]  rem_i;
		logic [RootBits-1:0] root;
		logic [QuotBits-1:0] qr;
		logic [QuotBits-1:0] qi;
	} dv_bin_t;

	function automatic logic [SampleBits-1:0] magnitude(logic [SampleBits-1:0] v);
		return v[SampleBits-1] ? (~v + SampleBits'(1)) : v;
	endfunction

	// Scales both parts together so that the larger has its top bit at position 14.
	function automatic logic [2*NormBits-1:0] normalize(logic [SampleBits-1:0] mr,
			logic [SampleBits-1:0] mi);
		logic [SampleBits-1:0]    o;
		logic [LeadBits-1:0]      p;
		logic [SampleBits+13:0]   wr;
		logic [SampleBits+13:0]   wi;
		o = mr | mi;
		p = '0;
		for (int i = 0; i < SampleBits; i++) begin
			if (o[i]) p = LeadBits'(i);
		end
		wr = {mr, 14'b0} >> p;
		wi = {mi, 14'b0} >> p;
		return {wr[NormBits-1:0], wi[NormBits-1:0]};
	endfunction

	// One bit of the square root, digit by digit from the top.
	function automatic sq_bin_t sqrt_step(sq_bin_t x, int j);
		logic [RemBits-1:0] t;
		sq_bin_t y;
		y = x;
		t = (RemBits'(x.root) << (j + 1)) + (RemBits'(1) << (2 * j));
		if (x.rem >= t) begin
			y.rem  = x.rem - t;
			y.root = x.root | (RootBits'(1) << j);
		end
		return y;
	endfunction

	// One quotient bit of both restoring divisions of a bin.
	function automatic dv_bin_t div_step(dv_bin_t x, int j);
		logic [DivBits-1:0] d;
		dv_bin_t y;
		y = x;
		d = DivBits'(x.root) << j;
		if (x.rem_r >= d) begin
			y.rem_r = x.rem_r - d;
			y.qr    = x.qr | (QuotBits'(1) << j);
		end
		if (x.rem_i >= d) begin
			y.rem_i = x.rem_i - d;
			y.qi    = x.qi | (QuotBits'(1) << j);
		end
		return y;
	endfunction

	function automatic logic signed [OutBits-1:0] to_unit(logic [QuotBits-1:0] q, logic neg);
		logic [QuotBits-1:0] c;
		c = (q > UnitMax) ? UnitMax : q;
		return neg ? OutBits'(-$signed({1'b0, c[OutBits-2:0]})) : $signed(c[OutBits-1:0]);
	endfunction

	// Q3.30 to Q1.15, ties away from zero, saturated.
	function automatic logic signed [OutBits-1:0] round_q15(logic signed [ProdBits-1:0] v);
		logic [ProdBits-1:0] mag;
		logic [ProdBits-1:0] q;
		mag = v[ProdBits-1] ? (~v + ProdBits'(1)) : v;
		q = (mag + ProdBits'(16384)) >> 15;
		if (v[ProdBits-1]) begin
			if (q > ProdBits'(32768)) q = ProdBits'(32768);
			return OutBits'(~q + ProdBits'(1));
		end
		if (q > ProdBits'(32767)) q = ProdBits'(32767);
		return OutBits'(q);
	endfunction

endpackage

// File: rtl/core/phat_cross_spectrum_bin.sv
// PHAT-weighted cross-power bin, fully pipelined.
// Depends on pcsb_pkg for beat types and arithmetic helpers.
//
// Usage: bins enter on the bin channel (bin_valid, bin_stall, bin_data) and
// results leave on the cross channel (cross_valid, cross_stall, cross_data).
// A beat moves when valid is high and stall is low at a rising clock edge.
// Each input bin pair is scaled to unit magnitude and the first is multiplied
// by the conjugate of the second; a zero bin gives zero and sets
// zero_magnitude. frame_end passes through with its bin.
// Throughput is one bin per clock unless cross_stall freezes the pipeline.
// Stages: magnitude, normalize, square, 32 square-root stages (a setup stage,
// then one root bit each for 31 bits), 17 divide stages (a setup stage, then
// one quotient bit each for 16 bits), then unit, product and rounding stages.
// Reset clears all valid bits; no result is presented after reset until a bin
// has gone through. When cross_stall holds the last stage full, the whole
// pipeline freezes and bin_stall rises in the same cycle; nothing is lost or
// repeated.
module phat_cross_spectrum_bin
	import pcsb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      bin_valid,
	output logic      bin_stall,
	input  in_beat_t  bin_data,
	output logic      cross_valid,
	input  logic      cross_stall,
	output out_beat_t cross_data
);

	logic en;

	logic                  vld_s1, vld_s2, vld_s3;
	side_t                 side_s1, side_s2, side_s3;
	logic [SampleBits-1:0] mar_s1, mai_s1, mbr_s1, mbi_s1;
	logic [NormBits-1:0]   nar_s2, nai_s2, nbr_s2, nbi_s2;
	logic [NormBits-1:0]   nar_s3, nai_s3, nbr_s3, nbi_s3;
	logic [2*NormBits-1:0] sar_s3, sai_s3, sbr_s3, sbi_s3;

	logic [SqSteps:0]      sq_vld_s;
	side_t                 sq_side_s [SqSteps+1];
	sq_bin_t               sqa_s     [SqSteps+1];
	sq_bin_t               sqb_s     [SqSteps+1];

	logic [DivSteps:0]     dv_vld_s;
	side_t                 dv_side_s [DivSteps+1];
	dv_bin_t               dva_s     [DivSteps+1];
	dv_bin_t               dvb_s     [DivSteps+1];

	logic                       vld_u, vld_p, vld_o;
	side_t                      side_u, side_p;
	logic signed [OutBits-1:0]  ar_u, ai_u, br_u, bi_u;
	logic signed [2*OutBits-1:0] p_rr, p_ii, p_ir, p_ri;
	out_beat_t                  out_q;

	logic [2*NormBits-1:0] na_w, nb_w;
	logic [SqBits-1:0]     sa_w, sb_w;
	logic signed [ProdBits-1:0] sum_r, sum_i;

	// The pipeline moves as a whole unless a finished result is held.
	assign en          = !(vld_o && cross_stall);
	assign bin_stall   = !en;
	assign cross_valid = vld_o;
	assign cross_data  = out_q;

	assign na_w = normalize(mar_s1, mai_s1);
	assign nb_w = normalize(mbr_s1, mbi_s1);
	assign sa_w = SqBits'(sar_s3) + SqBits'(sai_s3);
	assign sb_w = SqBits'(sbr_s3) + SqBits'(sbi_s3);
	assign sum_r = ProdBits'(p_rr) + ProdBits'(p_ii);
	assign sum_i = ProdBits'(p_ir) - ProdBits'(p_ri);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			sq_vld_s <= '0;
			dv_vld_s <= '0;
			vld_u    <= 1'b0;
			vld_p    <= 1'b0;
			vld_o    <= 1'b0;
		end else if (en) begin
			vld_s1   <= bin_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			sq_vld_s <= {sq_vld_s[SqSteps-1:0], vld_s3};
			dv_vld_s <= {dv_vld_s[DivSteps-1:0], sq_vld_s[SqSteps]};
			vld_u    <= dv_vld_s[DivSteps];
			vld_p    <= vld_u;
			vld_o    <= vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: sign and magnitude.
			mar_s1 <= magnitude(bin_data.first_real);
			mai_s1 <= magnitude(bin_data.first_imag);
			mbr_s1 <= magnitude(bin_data.second_real);
			mbi_s1 <= magnitude(bin_data.second_imag);
			side_s1.neg_ar    <= bin_data.first_real[SampleBits-1];
			side_s1.neg_ai    <= bin_data.first_imag[SampleBits-1];
			side_s1.neg_br    <= bin_data.second_real[SampleBits-1];
			side_s1.neg_bi    <= bin_data.second_imag[SampleBits-1];
			side_s1.zero      <= ((bin_data.first_real | bin_data.first_imag) == '0) ||
				((bin_data.second_real | bin_data.second_imag) == '0);
			side_s1.frame_end <= bin_data.frame_end;

			// Stage 2: normalize.
			{nar_s2, nai_s2} <= na_w;
			{nbr_s2, nbi_s2} <= nb_w;
			side_s2 <= side_s1;

			// Stage 3: squares, with the normalized parts kept alongside.
			sar_s3 <= nar_s2 * nar_s2;
			sai_s3 <= nai_s2 * nai_s2;
			sbr_s3 <= nbr_s2 * nbr_s2;
			sbi_s3 <= nbi_s2 * nbi_s2;
			nar_s3 <= nar_s2;
			nai_s3 <= nai_s2;
			nbr_s3 <= nbr_s2;
			nbi_s3 <= nbi_s2;
			side_s3 <= side_s2;

			// Square root of s * 2^30, one root bit per stage.
			sqa_s[0].mr   <= nar_s3;
			sqa_s[0].mi   <= nai_s3;
			sqb_s[0].mr   <= nbr_s3;
			sqb_s[0].mi   <= nbi_s3;
			sqa_s[0].rem  <= RemBits'(sa_w) << 30;
			sqb_s[0].rem  <= RemBits'(sb_w) << 30;
			sqa_s[0].root <= '0;
			sqb_s[0].root <= '0;
			sq_side_s[0]  <= side_s3;
			for (int k = 0; k < SqSteps; k++) begin
				sqa_s[k+1]     <= sqrt_step(sqa_s[k], SqSteps - 1 - k);
				sqb_s[k+1]     <= sqrt_step(sqb_s[k], SqSteps - 1 - k);
				sq_side_s[k+1] <= sq_side_s[k];
			end

			// Rounded division m * 2^30 / r, one quotient bit per stage.
			dva_s[0].rem_r <= (DivBits'(sqa_s[SqSteps].mr) << 30) +
				DivBits'(sqa_s[SqSteps].root >> 1);
			dva_s[0].rem_i <= (DivBits'(sqa_s[SqSteps].mi) << 30) +
				DivBits'(sqa_s[SqSteps].root >> 1);
			dva_s[0].root  <= sqa_s[SqSteps].root;
			dva_s[0].qr    <= '0;
			dva_s[0].qi    <= '0;
			dvb_s[0].rem_r <= (DivBits'(sqb_s[SqSteps].mr) << 30) +
				DivBits'(sqb_s[SqSteps].root >> 1);
			dvb_s[0].rem_i <= (DivBits'(sqb_s[SqSteps].mi) << 30) +
				DivBits'(sqb_s[SqSteps].root >> 1);
			dvb_s[0].root  <= sqb_s[SqSteps].root;
			dvb_s[0].qr    <= '0;
			dvb_s[0].qi    <= '0;
			dv_side_s[0]   <= sq_side_s[SqSteps];
			for (int k = 0; k < DivSteps; k++) begin
				dva_s[k+1]     <= div_step(dva_s[k], DivSteps - 1 - k);
				dvb_s[k+1]     <= div_step(dvb_s[k], DivSteps - 1 - k);
				dv_side_s[k+1] <= dv_side_s[k];
			end

			// Unit vectors with signs restored.
			ar_u   <= to_unit(dva_s[DivSteps].qr, dv_side_s[DivSteps].neg_ar);
			ai_u   <= to_unit(dva_s[DivSteps].qi, dv_side_s[DivSteps].neg_ai);
			br_u   <= to_unit(dvb_s[DivSteps].qr, dv_side_s[DivSteps].neg_br);
			bi_u   <= to_unit(dvb_s[DivSteps].qi, dv_side_s[DivSteps].neg_bi);
			side_u <= dv_side_s[DivSteps];

			// Products for a times conj(b).
			p_rr   <= ar_u * br_u;
			p_ii   <= ai_u * bi_u;
			p_ir   <= ai_u * br_u;
			p_ri   <= ar_u * bi_u;
			side_p <= side_u;

			// Round, saturate and mask zero bins.
			out_q.cross_real     <= side_p.zero ? '0 : round_q15(sum_r);
			out_q.cross_imag     <= side_p.zero ? '0 : round_q15(sum_i);
			out_q.zero_magnitude <= side_p.zero;
			out_q.frame_end_out  <= side_p.frame_end;
		end
	end

endmodule

// File: bench/tb_phat_cross_spectrum_bin.sv
// Testbench for the PHAT cross-spectrum bin: directed and random bin pairs,
// checked beat by beat against a predictor in this file. Depends on pcsb_pkg.
module tb_phat_cross_spectrum_bin;
	import pcsb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 55;
	localparam longint CycleLimit = 400000;

	logic      clk;
	logic      arst_n;
	logic      bin_valid;
	logic      bin_stall;
	in_beat_t  bin_data;
	logic      cross_valid;
	logic      cross_stall;
	out_beat_t cross_data;

	out_beat_t expected_cross[$];
	int        fail_count;
	longint    cycle_count;
	bit        hold_request;
	bit        quiet_receiver;

	phat_cross_spectrum_bin uut (
		.clk(clk), .arst_n(arst_n),
		.bin_valid(bin_valid), .bin_stall(bin_stall), .bin_data(bin_data),
		.cross_valid(cross_valid), .cross_stall(cross_stall), .cross_data(cross_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Unit-magnitude Q1.15 bin; returns 0 for a zero bin.
	function automatic bit unit_vector(logic signed [15:0] re, logic signed [15:0] im,
			output longint ur, output longint ui);
		longint unsigned mr, mi, s, r, qr, qi;
		mr = re[15] ? 64'd65536 - {48'd0, re} : {48'd0, re};
		mi = im[15] ? 64'd65536 - {48'd0, im} : {48'd0, im};
		ur = 0;
		ui = 0;
		if ((mr | mi) == 0) return 1'b0;
		while ((mr | mi) >= 32768) begin
			mr >>= 1;
			mi >>= 1;
		end
		while ((mr | mi) < 16384) begin
			mr <<= 1;
			mi <<= 1;
		end
		s = mr * mr + mi * mi;
		r = int_sqrt(s << 30);
		qr = ((mr << 30) + (r >> 1)) / r;
		qi = ((mi << 30) + (r >> 1)) / r;
		if (qr > 32767) qr = 32767;
		if (qi > 32767) qi = 32767;
		ur = re[15] ? -longint'(qr) : longint'(qr);
		ui = im[15] ? -longint'(qi) : longint'(qi);
		return 1'b1;
	endfunction

	function automatic logic signed [15:0] to_q15(longint v);
		longint unsigned q;
		q = ((v < 0 ? -v : v) + 16384) >> 15;
		if (v < 0) begin
			if (q > 32768) q = 32768;
			return 16'(-longint'(q));
		end
		if (q > 32767) q = 32767;
		return 16'(q);
	endfunction

	function automatic out_beat_t predict_cross(in_beat_t b);
		out_beat_t o;
		longint ar, ai, br, bi;
		bit ok_a, ok_b;
		ok_a = unit_vector(b.first_real, b.first_imag, ar, ai);
		ok_b = unit_vector(b.second_real, b.second_imag, br, bi);
		o.frame_end_out = b.frame_end;
		if (!ok_a || !ok_b) begin
			o.cross_real = '0;
			o.cross_imag = '0;
			o.zero_magnitude = 1'b1;
		end else begin
			o.cross_real = to_q15(ar * br + ai * bi);
			o.cross_imag = to_q15(ai * br - ar * bi);
			o.zero_magnitude = 1'b0;
		end
		return o;
	endfunction

	function automatic int short_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
	endfunction

	task automatic send_bin(in_beat_t b);
		bin_valid <= 1'b1;
		bin_data <= b;
		expected_cross.push_back(predict_cross(b));
		@(posedge clk);
		while (bin_stall) @(posedge clk);
	endtask

	// Random gaps between beats when gappy is set; the valid stays high otherwise.
	task automatic send_with_gap(in_beat_t b, bit gappy);
		int g;
		send_bin(b);
		g = gappy ? short_gap() : 0;
		if (g > 0) begin
			bin_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic in_beat_t pair(int fr, int fi, int sr, int si, bit fe);
		in_beat_t b;
		b.first_real = 16'(fr);
		b.first_imag = 16'(fi);
		b.second_real = 16'(sr);
		b.second_imag = 16'(si);
		b.frame_end = fe;
		return b;
	endfunction

	function automatic logic [15:0] random_part();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 3)) - 16'd1;
			1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			2: return 16'($urandom_range(0, 255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_beat_t random_bin();
		in_beat_t b;
		b.first_real = random_part();
		b.first_imag = random_part();
		b.second_real = random_part();
		b.second_imag = random_part();
		if ($urandom_range(0, 15) == 0) begin
			b.first_real = '0;
			b.first_imag = '0;
		end
		if ($urandom_range(0, 15) == 0) begin
			b.second_real = '0;
			b.second_imag = '0;
		end
		b.frame_end = ($urandom_range(0, 7) == 0);
		return b;
	endfunction

	task automatic test_extremes();
		send_with_gap(pair(32767, 0, 32767, 0, 0), 0);
		send_with_gap(pair(-32768, 0, -32768, 0, 1), 0);
		send_with_gap(pair(-32768, -32768, 32767, 32767, 0), 0);
		send_with_gap(pair(32767, -32768, -32768, 32767, 1), 0);
		send_with_gap(pair(0, 32767, 32767, 0, 0), 1);
		send_with_gap(pair(0, -32768, 0, 1, 0), 1);
		send_with_gap(pair(1, 0, 0, -1, 1), 0);
		send_with_gap(pair(-1, -1, 1, 1, 0), 0);
		send_with_gap(pair(3, 4, -4, 3, 0), 0);
		send_with_gap(pair(16384, 16384, 16384, -16384, 1), 0);
		send_with_gap(pair(21845, 10922, -7, 100, 0), 0);
		send_with_gap(pair(-1, 0, 0, 1, 1), 0);
	endtask

	task automatic test_zero_bins();
		send_with_gap(pair(0, 0, 1000, -200, 0), 0);
		send_with_gap(pair(5, 5, 0, 0, 1), 1);
		send_with_gap(pair(0, 0, 0, 0, 0), 0);
		send_with_gap(pair(0, 0, -32768, -32768, 1), 0);
		send_with_gap(pair(-32768, 32767, 0, 0, 0), 0);
	endtask

	task automatic test_random_stream(int count);
		for (int i = 0; i < count; i++) send_with_gap(random_bin(), (i % 200) >= 60);
		bin_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The receiver holds off while bins keep coming, so the pipeline fills and stalls.
	task automatic test_back_pressure();
		hold_request = 1'b1;
		for (int i = 0; i < 150; i++) send_with_gap(random_bin(), 0);
		bin_valid <= 1'b0;
		hold_request = 1'b0;
		@(posedge clk);
	endtask

	// Receiver stall: random gaps, a quiet stretch, or a long counted hold.
	initial begin
		int n;
		cross_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				cross_stall <= 1'b1;
				for (n = 0; n < 300; n++) @(posedge clk);
				cross_stall <= 1'b0;
				while (hold_request) @(posedge clk);
			end else if (quiet_receiver) begin
				cross_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				cross_stall <= 1'b1;
				repeat (short_gap() + 1) @(posedge clk);
				cross_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && cross_valid && !cross_stall) begin
			if (expected_cross.size() == 0) begin
				$error("unexpected result beat %h", cross_data);
				fail_count++;
			end else begin
				e = expected_cross.pop_front();
				if (cross_data.cross_real !== e.cross_real) begin
					$error("cross_real expected %0d actual %0d", e.cross_real,
						cross_data.cross_real);
					fail_count++;
				end
				if (cross_data.cross_imag !== e.cross_imag) begin
					$error("cross_imag expected %0d actual %0d", e.cross_imag,
						cross_data.cross_imag);
					fail_count++;
				end
				if (cross_data.zero_magnitude !== e.zero_magnitude) begin
					$error("zero_magnitude expected %b actual %b", e.zero_magnitude,
						cross_data.zero_magnitude);
					fail_count++;
				end
				if (cross_data.frame_end_out !== e.frame_end_out) begin
					$error("frame_end_out expected %b actual %b", e.frame_end_out,
						cross_data.frame_end_out);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("FAIL phat_cross_spectrum_bin");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		cycle_count = 0;
		hold_request = 1'b0;
		quiet_receiver = 1'b0;
		arst_n = 1'b0;
		bin_valid <= 1'b0;
		bin_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		quiet_receiver = 1'b1;
		test_extremes();
		quiet_receiver = 1'b0;
		test_zero_bins();
		test_random_stream(500);
		test_back_pressure();
		test_random_stream(450);
		while (expected_cross.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS phat_cross_spectrum_bin");
		end else begin
			$display("FAIL phat_cross_spectrum_bin");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/pcsb_pkg.sv
rtl/core/phat_cross_spectrum_bin.sv
bench/tb_phat_cross_spectrum_bin.sv
